@@ rtl/assert_macros.svh @@
// Assertion macros for the path-follow steering RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is held.
`define PFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked property that also holds during reset.
`define PFS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/pfs_pkg.sv @@
// Package for the path-follow steering block: widths, fixed-point constants,
// CORDIC arctangent table and output rounding. No dependencies.
package pfs_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int DW = 40;               // distance datapath, 2^-20 m units
  localparam int ZW = 34;               // CORDIC angle accumulator
  localparam int MB = 34;               // multiplier B width = serial steps
  localparam int PW = DW + 1 + MB;      // product width
  localparam int CW = 5;                // CORDIC step counter
  localparam int MCW = 6;               // multiplier step counter

  localparam logic signed [MB-1:0] K_Q30      = 34'sd652032874;
  localparam logic signed [MB-1:0] TWO_PI_Q24 = 34'sd105414357;

  function automatic logic [ZW-1:0] atan_entry(input logic [CW-1:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051D;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2E;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return {{(ZW-32){1'b0}}, v};
  endfunction

  // Q7.8 metres to 2^-20 m.
  function automatic logic signed [DW-1:0] q_scale(input logic signed [15:0] v);
    return {{(DW-28){v[15]}}, v, 12'h000};
  endfunction

  function automatic logic signed [DW-1:0] u_scale(input logic [14:0] v);
    return {{(DW-27){1'b0}}, v, 12'h000};
  endfunction

  // Round half up back to Q7.8 and saturate.
  function automatic logic signed [15:0] to_q78(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] s;
    logic signed [DW-1:0] r;
    s = v + DW'(2048);
    r = s >>> 12;
    if (r > DW'(32767)) return 16'sh7FFF;
    else if (r < -DW'(32768)) return 16'sh8000;
    else return r[15:0];
  endfunction

endpackage

@@ rtl/path_follow_steering.sv @@
// Path-follow steering top level: sequencer, shared CORDIC and bit-serial
// multiplier. Depends on pfs_pkg and assert_macros.svh.
//
// Usage: a pose beat (in_pos_x, in_pos_y, in_heading) is taken when in_valid
// is high and in_stall low; in_stall is high while a pose is being worked.
// Each pose gives one result beat (speed, turn rate, carrot point) on the
// out_ channel, held stable while out_stall is high. The next pose may be
// taken while a finished result still waits on the output register.
// A pose where the carrot is within the stop distance (commands held) skips
// the last two multiplies that a new steering command needs; a vectoring run
// on a zero vector ends at once. The work is done by one shared CORDIC unit
// (16 steps a run, five runs) and one shift-add multiplier that retires one
// bit of its 34-bit operand a cycle. A new pose is taken only after the last
// one has finished; if the receiver stalls with a result still waiting, the
// next result waits in the final state and the pose after it is not taken.
// Configuration writes (cfg_index, cfg_data) are always ready and must only
// be issued while the block is idle. Reset loads the default waypoints and
// gains and clears the held speed and turn commands to zero.
`include "assert_macros.svh"

module path_follow_steering (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_pos_x,
  input  logic [15:0] in_pos_y,
  input  logic [15:0] in_heading,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] out_speed_cmd,
  output logic [13:0] out_turn_cmd,
  output logic [15:0] out_carrot_x,
  output logic [15:0] out_carrot_y,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int DW = pfs_pkg::DW;
  localparam int ZW = pfs_pkg::ZW;
  localparam int MB = pfs_pkg::MB;
  localparam int PW = pfs_pkg::PW;
  localparam int CW = pfs_pkg::CW;
  localparam int MCW = pfs_pkg::MCW;

  typedef enum logic [3:0] {
    S_IDLE, S_V1, S_V2, S_M_RU, S_R1, S_M_R, S_R2, S_M_XC, S_M_YC,
    S_V3, S_M_D, S_M_RAD, S_M_T, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    REG_START_X, REG_START_Y, REG_END_X, REG_END_Y,
    REG_LOOKAHEAD, REG_STEER_GAIN, REG_CRUISE, REG_STOP
  } reg_idx_t;

  state_t state_r;

  // configuration
  logic signed [15:0] sx_r, sy_r, ex_r, ey_r;
  logic [14:0] la_r, cruise_r, stop_r;
  logic [15:0] gain_r;

  // pose and intermediates
  logic signed [15:0] px_r, py_r;
  logic [15:0] hdg_r;
  logic [31:0] th_r, thu_r, thd_r;
  logic signed [DW-1:0] ru_r, len_r, st_r, xc_r, yc_r;
  logic [14:0] pend_speed_r, speed_r;
  logic signed [13:0] pend_turn_r, turn_r;
  logic out_valid_r;
  logic signed [15:0] cx_out_r, cy_out_r;

  // CORDIC
  logic signed [DW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0] cz_r;
  logic [CW-1:0] ci_r;
  logic rot_r, flip_r;

  // serial multiplier
  logic signed [DW-1:0] ma_r;
  logic signed [DW:0] mhi_r;
  logic [MB-1:0] mlo_r;
  logic [MCW-1:0] mcnt_r;

  logic cdone, mdone;
  logic signed [DW-1:0] xs, ys, rot_c, rot_s, cb_abs;
  logic [ZW-1:0] tab;
  logic signed [DW-1:0] cx_it, cy_it;
  logic signed [ZW-1:0] cz_it;
  logic signed [DW:0] m_add, m_sum;
  logic signed [PW-1:0] prod, p30, p32, p24;
  logic signed [DW-1:0] sh30, sh32, sh24, yc_new;
  logic signed [DW-1:0] vin_x, vin_y, ma_in;
  logic signed [MB-1:0] mb_in;
  logic [31:0] rin, err;
  logic signed [ZW-1:0] rz0, rz1;
  logic rneed_flip;
  logic signed [13:0] t_clamp;

  assign cdone = (ci_r == CW'(pfs_pkg::CORDIC_STEPS));
  assign mdone = (mcnt_r == MCW'(MB));

  // one CORDIC step
  always_comb begin
    xs  = cx_r >>> ci_r;
    ys  = cy_r >>> ci_r;
    tab = pfs_pkg::atan_entry(ci_r);
    if (!rot_r) begin
      if (!cy_r[DW-1]) begin
        cx_it = cx_r + ys; cy_it = cy_r - xs; cz_it = cz_r + $signed(tab);
      end else begin
        cx_it = cx_r - ys; cy_it = cy_r + xs; cz_it = cz_r - $signed(tab);
      end
    end else begin
      if (!cz_r[ZW-1]) begin
        cx_it = cx_r - ys; cy_it = cy_r + xs; cz_it = cz_r - $signed(tab);
      end else begin
        cx_it = cx_r + ys; cy_it = cy_r - xs; cz_it = cz_r + $signed(tab);
      end
    end
  end

  assign rot_c  = flip_r ? -cx_r : cx_r;
  assign rot_s  = flip_r ? -cy_r : cy_r;
  assign cb_abs = rot_c[DW-1] ? -rot_c : rot_c;

  // one multiplier step; the top bit of B has negative weight
  always_comb begin
    if (!mlo_r[0]) m_add = '0;
    else if (mcnt_r == MCW'(MB - 1)) m_add = -{ma_r[DW-1], ma_r};
    else m_add = {ma_r[DW-1], ma_r};
    m_sum = mhi_r + m_add;
  end

  assign prod   = $signed({mhi_r, mlo_r});
  assign p30    = prod >>> 30;
  assign p32    = prod >>> 32;
  assign p24    = prod >>> 24;
  assign sh30   = p30[DW-1:0];
  assign sh32   = p32[DW-1:0];
  assign sh24   = p24[DW-1:0];
  assign yc_new = sh30 + pfs_pkg::q_scale(sy_r);
  assign err    = {hdg_r, 16'h0000} - thd_r;

  always_comb begin
    if (sh24 > DW'(4096)) t_clamp = 14'sd4096;
    else if (sh24 < -DW'(4096)) t_clamp = -14'sd4096;
    else t_clamp = sh24[13:0];
  end

  // operands for the next CORDIC or multiplier run
  always_comb begin
    unique case (state_r)
      S_IDLE: begin
        vin_x = pfs_pkg::q_scale(ex_r) - pfs_pkg::q_scale(sx_r);
        vin_y = pfs_pkg::q_scale(ey_r) - pfs_pkg::q_scale(sy_r);
      end
      S_V1: begin
        vin_x = pfs_pkg::q_scale(sx_r) - pfs_pkg::q_scale(px_r);
        vin_y = pfs_pkg::q_scale(sy_r) - pfs_pkg::q_scale(py_r);
      end
      default: begin
        vin_x = pfs_pkg::q_scale(px_r) - xc_r;
        vin_y = pfs_pkg::q_scale(py_r) - yc_new;
      end
    endcase
  end

  always_comb begin
    unique case (state_r)
      S_R1:    begin ma_in = ru_r;  mb_in = cb_abs[MB-1:0]; end
      S_R2:    begin ma_in = len_r; mb_in = rot_c[MB-1:0]; end
      S_M_XC:  begin ma_in = len_r; mb_in = st_r[MB-1:0]; end
      S_M_D:   begin ma_in = {{(DW-32){err[31]}}, err}; mb_in = pfs_pkg::TWO_PI_Q24; end
      S_M_RAD: begin ma_in = sh32;  mb_in = {{(MB-16){1'b0}}, gain_r}; end
      default: begin ma_in = cx_r;  mb_in = pfs_pkg::K_Q30; end
    endcase
  end

  assign rin        = (state_r == S_M_RU) ? (th_r - thu_r) : th_r;
  assign rz0        = {{(ZW-32){rin[31]}}, rin};
  assign rneed_flip = (rz0 > ZW'(1 << 30)) || (rz0 < -ZW'(1 << 30));
  assign rz1        = {{(ZW-32){~rin[31]}}, ~rin[31], rin[30:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      speed_r     <= '0;
      turn_r      <= '0;
      sx_r        <= -16'sd768;
      sy_r        <= 16'sd384;
      ex_r        <= 16'sd1024;
      ey_r        <= 16'sd384;
      la_r        <= 15'd102;
      gain_r      <= 16'd3277;
      cruise_r    <= 15'd384;
      stop_r      <= 15'd26;
      ci_r        <= CW'(pfs_pkg::CORDIC_STEPS);
      mcnt_r      <= MCW'(MB);
    end else begin
      if (cfg_valid) begin
        unique case (reg_idx_t'(cfg_index))
          REG_START_X:    sx_r     <= cfg_data;
          REG_START_Y:    sy_r     <= cfg_data;
          REG_END_X:      ex_r     <= cfg_data;
          REG_END_Y:      ey_r     <= cfg_data;
          REG_LOOKAHEAD:  la_r     <= cfg_data[14:0];
          REG_STEER_GAIN: gain_r   <= cfg_data;
          REG_CRUISE:     cruise_r <= cfg_data[14:0];
          REG_STOP:       stop_r   <= cfg_data[14:0];
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      if (!cdone) begin
        cx_r <= cx_it;
        cy_r <= cy_it;
        cz_r <= cz_it;
        ci_r <= ci_r + CW'(1);
      end

      if (!mdone) begin
        mhi_r  <= {m_sum[DW], m_sum[DW:1]};
        mlo_r  <= {m_sum[0], mlo_r[MB-1:1]};
        mcnt_r <= mcnt_r + MCW'(1);
      end

      unique case (state_r)
        S_IDLE: if (in_valid) begin
          px_r  <= in_pos_x;
          py_r  <= in_pos_y;
          hdg_r <= in_heading;
          state_r <= S_V1;
        end
        S_V1: if (cdone) begin
          th_r    <= cz_r[31:0];
          state_r <= S_V2;
        end
        S_V2: if (cdone) begin
          thu_r   <= cz_r[31:0];
          state_r <= S_M_RU;
        end
        S_M_RU: if (mdone) begin
          ru_r    <= sh30;
          state_r <= S_R1;
        end
        S_R1: if (cdone) state_r <= S_M_R;
        S_M_R: if (mdone) begin
          len_r   <= sh30 + pfs_pkg::u_scale(la_r);
          state_r <= S_R2;
        end
        S_R2: if (cdone) begin
          st_r    <= rot_s;
          state_r <= S_M_XC;
        end
        S_M_XC: if (mdone) begin
          xc_r    <= sh30 + pfs_pkg::q_scale(sx_r);
          state_r <= S_M_YC;
        end
        S_M_YC: if (mdone) begin
          yc_r    <= yc_new;
          state_r <= S_V3;
        end
        S_V3: if (cdone) begin
          thd_r   <= cz_r[31:0];
          state_r <= S_M_D;
        end
        S_M_D: if (mdone) begin
          if (sh30 > pfs_pkg::u_scale(stop_r)) begin
            pend_speed_r <= cruise_r;
            state_r      <= S_M_RAD;
          end else begin
            pend_speed_r <= speed_r;
            pend_turn_r  <= turn_r;
            state_r      <= S_DONE;
          end
        end
        S_M_RAD: if (mdone) state_r <= S_M_T;
        S_M_T: if (mdone) begin
          pend_turn_r <= t_clamp;
          state_r     <= S_DONE;
        end
        S_DONE: if (!out_valid_r || !out_stall) begin
          speed_r     <= pend_speed_r;
          turn_r      <= pend_turn_r;
          cx_out_r    <= pfs_pkg::to_q78(xc_r);
          cy_out_r    <= pfs_pkg::to_q78(yc_r);
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase

      // launch vectoring runs
      if ((state_r == S_IDLE && in_valid) || (state_r == S_V1 && cdone) ||
          (state_r == S_M_YC && mdone)) begin
        rot_r  <= 1'b0;
        flip_r <= 1'b0;
        if (vin_x == '0 && vin_y == '0) begin
          cx_r <= '0; cy_r <= '0; cz_r <= '0;
          ci_r <= CW'(pfs_pkg::CORDIC_STEPS);
        end else if (vin_x[DW-1]) begin
          cx_r <= -vin_x; cy_r <= -vin_y;
          cz_r <= ZW'(34'h080000000);
          ci_r <= '0;
        end else begin
          cx_r <= vin_x; cy_r <= vin_y; cz_r <= '0;
          ci_r <= '0;
        end
      end

      // launch rotation runs
      if ((state_r == S_M_RU || state_r == S_M_R) && mdone) begin
        rot_r  <= 1'b1;
        flip_r <= rneed_flip;
        cz_r   <= rneed_flip ? rz1 : rz0;
        cx_r   <= {{(DW-MB){1'b0}}, pfs_pkg::K_Q30};
        cy_r   <= '0;
        ci_r   <= '0;
      end

      // launch multiplies
      if (((state_r == S_V2 || state_r == S_R1 || state_r == S_R2 ||
            state_r == S_V3) && cdone) ||
          ((state_r == S_M_XC || state_r == S_M_RAD) && mdone) ||
          (state_r == S_M_D && mdone && sh30 > pfs_pkg::u_scale(stop_r))) begin
        ma_r   <= ma_in;
        mhi_r  <= '0;
        mlo_r  <= mb_in;
        mcnt_r <= '0;
      end
    end
  end

  assign in_stall      = (state_r != S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_speed_cmd = speed_r;
  assign out_turn_cmd  = turn_r;
  assign out_carrot_x  = cx_out_r;
  assign out_carrot_y  = cy_out_r;

  `PFS_ASSERT(a_accept_starts, (in_valid && !in_stall) |=> (state_r == S_V1), "pose beat did not start work")
  `PFS_ASSERT(a_mcnt_range, (mcnt_r <= MCW'(MB)), "multiplier counter out of range")
  `PFS_ASSERT(a_turn_sat, out_valid |-> ($signed(out_turn_cmd) <= 14'sd4096 && $signed(out_turn_cmd) >= -14'sd4096), "turn command beyond saturation")
  `PFS_ASSERT(a_done_emits, (state_r == S_DONE && !out_stall) |=> out_valid, "result not presented")

endmodule
